>>> design/deq_pkg.sv
// Package for the double-ended queue: shared widths, request and status codes,
// payload structs and the control struct handed from the top level to the cells.
// No dependencies.
package deq_pkg;

  // Fixed field widths of the payload and the default queue depth
  localparam int unsigned WIDTH         = 32;
  localparam int unsigned COUNT_W       = 5;
  localparam int unsigned DEPTH_DEFAULT = 16;

  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_BACK  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_BACK   = 2'd3
  } deq_req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } deq_status_e;

  // Input request payload
  typedef struct packed {
    deq_req_e          req_type;
    logic [WIDTH-1:0]  push_value;
  } deq_req_t;

  // Response payload
  typedef struct packed {
    logic [WIDTH-1:0]   pop_value;
    logic               pop_valid;
    deq_status_e        status;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
  } deq_rsp_t;

  // Shift command broadcast to every cell; at most one operation is set
  typedef struct packed {
    logic             ins_front;
    logic             ins_back;
    logic             rem_front;
    logic             rem_back;
    logic [WIDTH-1:0] value;
  } deq_ctrl_t;

  // What a cell shows to its neighbours
  typedef struct packed {
    logic             occ;
    logic [WIDTH-1:0] value;
  } deq_link_t;

endpackage

>>> design/deq_cell.sv
// One storage cell of the deque row: an occupancy bit and one entry.
// Depends on deq_pkg.
module deq_cell import deq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  deq_ctrl_t        ctrl_i,
  input  deq_link_t        left_i,
  input  deq_link_t        right_i,
  output deq_link_t        self_o,
  output logic [WIDTH-1:0] back_o
);

  logic             occ_q, occ_d;
  logic [WIDTH-1:0] value_q, value_d;
  logic             is_back;

  // This cell holds the back element when the next cell is empty
  assign is_back = occ_q && !right_i.occ;

  // Next state: shift right on push front, left on pop front, local edits at the back
  always_comb begin
    occ_d   = occ_q;
    value_d = value_q;
    if (ctrl_i.ins_front) begin
      occ_d   = left_i.occ;
      value_d = left_i.value;
    end else if (ctrl_i.rem_front) begin
      occ_d   = right_i.occ;
      value_d = right_i.value;
    end else if (ctrl_i.ins_back) begin
      if (!occ_q && left_i.occ) begin
        occ_d   = 1'b1;
        value_d = ctrl_i.value;
      end
    end else if (ctrl_i.rem_back) begin
      if (is_back) begin
        occ_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // Entry itself needs no reset; occupancy guards it
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign self_o.occ   = occ_q;
  assign self_o.value = value_q;
  assign back_o       = is_back ? value_q : '0;

endmodule

>>> design/double_ended_queue_unit.sv
// Top level of the bounded double-ended queue: a row of shifting cells,
// the element counter and the registered response stage. Depends on deq_pkg, deq_cell.
//
//   channel  direction  handshake                     payload
//   request  in         req_valid_i / req_stall_o     req_i  (deq_req_t)
//   response out        rsp_valid_o / rsp_stall_i     rsp_o  (deq_rsp_t)
//
// One request is taken per cycle while the response is not stalled; its response
// appears in the output register on the next cycle. For every request the cell
// row shifts or edits all cells in parallel. A stalled response holds the output
// register, and a new request is taken only when that register is free or
// being taken in the same cycle. Reset empties the queue at once.
module double_ended_queue_unit import deq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_stall_o,
  input  deq_req_t req_i,
  output logic     rsp_valid_o,
  input  logic     rsp_stall_i,
  output deq_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic             accept;
  logic             full, empty;
  logic [CntW-1:0]  count_q, count_d;
  deq_ctrl_t        ctrl;
  deq_link_t        link   [DEPTH];
  logic [WIDTH-1:0] back   [DEPTH];
  logic [DEPTH-1:0] occ;
  logic [WIDTH-1:0] back_value;
  deq_link_t        head, tail;
  deq_rsp_t         rsp_d, rsp_q;
  logic             rsp_valid_q;

  assign req_stall_o = rsp_valid_q && rsp_stall_i;
  assign accept      = req_valid_i && !req_stall_o;
  assign full        = (count_q == CntW'(DEPTH));
  assign empty       = (count_q == '0);

  // Command to the cells, gated by acceptance and by full/empty
  always_comb begin
    ctrl            = '0;
    ctrl.value      = req_i.push_value;
    if (accept) begin
      case (req_i.req_type)
        REQ_PUSH_FRONT: ctrl.ins_front = !full;
        REQ_PUSH_BACK:  ctrl.ins_back  = !full;
        REQ_POP_FRONT:  ctrl.rem_front = !empty;
        REQ_POP_BACK:   ctrl.rem_back  = !empty;
        default:        ctrl           = ctrl;
      endcase
    end
  end

  // Ends of the row: a pushed value enters at cell 0, empty space beyond the last
  assign head.occ   = 1'b1;
  assign head.value = req_i.push_value;
  assign tail.occ   = 1'b0;
  assign tail.value = '0;

  // Cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    deq_link_t left_l, right_l;
    if (i == 0) begin : g_first
      assign left_l = head;
    end else begin : g_mid_l
      assign left_l = link[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_l = tail;
    end else begin : g_mid_r
      assign right_l = link[i+1];
    end
    deq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .left_i  (left_l),
      .right_i (right_l),
      .self_o  (link[i]),
      .back_o  (back[i])
    );
    assign occ[i] = link[i].occ;
  end

  // Only the back cell drives a non-zero value
  always_comb begin
    back_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_value = back_value | back[i];
    end
  end

  // Counter and response
  always_comb begin
    count_d         = count_q;
    rsp_d           = '0;
    rsp_d.status    = ST_OK;
    case (req_i.req_type)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (full) begin
          rsp_d.status = ST_PUSH_FULL;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (empty) begin
          rsp_d.status = ST_POP_EMPTY;
        end else begin
          count_d         = count_q - CntW'(1);
          rsp_d.pop_valid = 1'b1;
          rsp_d.pop_value = (req_i.req_type == REQ_POP_FRONT) ? link[0].value : back_value;
        end
      end
      default: count_d = count_q;
    endcase
    rsp_d.count    = COUNT_W'(count_d);
    rsp_d.is_empty = (count_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (!rsp_stall_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Response payload register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // Counter tracks the number of occupied cells
  a_count_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(occ) == int'(count_q))
    else $error("element counter disagrees with cell occupancy");

  // Occupied cells form one run starting at cell 0
  a_occ_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (({1'b0, occ} + {{DEPTH{1'b0}}, 1'b1}) & {1'b0, occ}) == '0)
    else $error("cell occupancy is not contiguous from the front");

  // A pop on a non-empty queue returns data and decrements the count
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && ((req_i.req_type == REQ_POP_FRONT) || (req_i.req_type == REQ_POP_BACK))
      && !empty |=> rsp_o.pop_valid && ($past(count_q) == count_q + CntW'(1)))
    else $error("successful pop did not decrement the count");

  // A push on full leaves the count untouched and reports ST_PUSH_FULL
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && full && ((req_i.req_type == REQ_PUSH_FRONT) || (req_i.req_type == REQ_PUSH_BACK))
      |=> $stable(count_q) && (rsp_o.status == ST_PUSH_FULL))
    else $error("push on full changed the queue");

endmodule

>>> test/double_ended_queue_unit_test.sv
// Self-checking testbench for double_ended_queue_unit: pushes and pops at both
// ends, an internal ring-store predictor and an in-order response scoreboard.
// Depends on deq_pkg and the double_ended_queue_unit RTL.
`timescale 1ns / 1ps

module double_ended_queue_unit_test;
  import deq_pkg::*;

  localparam int unsigned QDEPTH      = DEPTH_DEFAULT;
  localparam int unsigned IDX_W       = $clog2(QDEPTH);
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned STALL_LIMIT = 4000;

  typedef enum int {
    PH_STEADY,
    PH_SENDER_SLOW,
    PH_RECEIVER_SLOW,
    PH_BOTH,
    PH_HOLD
  } tb_phase_e;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     req_valid_i = 1'b0;
  logic     req_stall_o;
  deq_req_t req_i       = '0;
  logic     rsp_valid_o;
  logic     rsp_stall_i = 1'b0;
  deq_rsp_t rsp_o;

  double_ended_queue_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_stall_o (req_stall_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_stall_i (rsp_stall_i),
    .rsp_o       (rsp_o)
  );

  // Stimulus and scoreboard storage
  deq_req_t  pending_reqs[$];
  deq_rsp_t  expected_rsps[$];
  tb_phase_e phase = PH_STEADY;
  logic      req_taken = 1'b0;
  int        reqs_queued = 0;
  int        reqs_accepted = 0;
  int        rsps_checked = 0;
  int        error_count = 0;
  int        quiet_cycles = 0;

  // Predicted queue state
  logic [WIDTH-1:0]   ring_mem [QDEPTH];
  logic [IDX_W-1:0]   head_slot = '0;
  logic [COUNT_W-1:0] fill_level = '0;
  int                 empty_pops = 0;
  int                 full_pushes = 0;
  int                 fullest = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Apply one request to the predicted queue and return its response
  function automatic deq_rsp_t apply_request(input deq_req_t rq);
    deq_rsp_t         r;
    logic [IDX_W-1:0] tail_slot;
    r = '0;
    r.status = ST_OK;
    tail_slot = head_slot + fill_level[IDX_W-1:0];
    case (rq.req_type)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (fill_level == QDEPTH) begin
          r.status = ST_PUSH_FULL;
          full_pushes++;
        end else begin
          if (rq.req_type == REQ_PUSH_FRONT) begin
            head_slot = head_slot - 1'b1;
            ring_mem[head_slot] = rq.push_value;
          end else begin
            ring_mem[tail_slot] = rq.push_value;
          end
          fill_level++;
        end
      end
      default: begin
        if (fill_level == 0) begin
          r.status = ST_POP_EMPTY;
          empty_pops++;
        end else begin
          if (rq.req_type == REQ_POP_FRONT) begin
            r.pop_value = ring_mem[head_slot];
            head_slot = head_slot + 1'b1;
          end else begin
            r.pop_value = ring_mem[tail_slot - 1'b1];
          end
          r.pop_valid = 1'b1;
          fill_level--;
        end
      end
    endcase
    if (fill_level > fullest) fullest = fill_level;
    r.count    = fill_level;
    r.is_empty = (fill_level == 0);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [WIDTH-1:0] want,
                             input logic [WIDTH-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  task automatic add_req(input deq_req_e kind, input logic [WIDTH-1:0] value);
    deq_req_t rq;
    rq.req_type   = kind;
    rq.push_value = value;
    pending_reqs = {pending_reqs, rq};
    reqs_queued++;
  endtask

  // Runs of pushes reach full, runs of pops drain past empty, mixed runs are noise
  task automatic queue_random(input int n);
    int               left;
    int               run;
    int               kind;
    deq_req_e         op;
    logic [WIDTH-1:0] value;
    left = n;
    while (left > 0) begin
      kind = $urandom_range(9);
      run  = $urandom_range(20, 4);
      if (run > left) run = left;
      repeat (run) begin
        if (kind < 3) op = deq_req_e'($urandom_range(1));
        else if (kind < 6) op = deq_req_e'($urandom_range(3, 2));
        else op = deq_req_e'($urandom_range(3));
        case ($urandom_range(7))
          0: value = '0;
          1: value = '1;
          2: value = 1 << $urandom_range(WIDTH - 1);
          default: value = $urandom;
        endcase
        add_req(op, value);
      end
      left -= run;
    end
  endtask

  // Wait until every queued request is taken and every response checked
  task automatic wait_drained();
    while (reqs_accepted != reqs_queued || expected_rsps.size() != 0)
      @(posedge clk_i);
  endtask

  // Request driver
  always @(negedge clk_i) begin : drive_req
    int idle_pct;
    case (phase)
      PH_SENDER_SLOW: idle_pct = 85;
      PH_BOTH:        idle_pct = 7;
      default:        idle_pct = 0;
    endcase
    if (rst_ni && (!req_valid_i || req_taken)) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
        req_i       <= pending_reqs[0];
        req_valid_i <= 1'b1;
        pending_reqs.delete(0);
      end else begin
        req_valid_i <= 1'b0;
      end
    end
  end

  // Response receiver: random stalls, plus one long hold-off
  always @(negedge clk_i) begin : drive_stall
    int          stall_pct;
    int unsigned hold_left;
    bit          hold_spent;
    case (phase)
      PH_RECEIVER_SLOW: stall_pct = 85;
      PH_BOTH:          stall_pct = 7;
      default:          stall_pct = 0;
    endcase
    if (phase == PH_HOLD && !hold_spent) begin
      hold_spent = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_stall_i <= 1'b1;
    end else begin
      rsp_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: predicts on each taken request, checks each taken response
  always @(posedge clk_i) begin : monitor
    deq_rsp_t want;
    bit       moved;
    if (rst_ni) begin
      moved = 1'b0;
      req_taken <= req_valid_i && !req_stall_o;
      if (rsp_valid_o && !rsp_stall_i) begin
        moved = 1'b1;
        rsps_checked++;
        if (expected_rsps.size() == 0) begin
          $error("response with no request outstanding");
          error_count++;
        end else begin
          want = expected_rsps[0];
          expected_rsps.delete(0);
          check_field("pop_value", want.pop_value, rsp_o.pop_value);
          check_field("pop_valid", want.pop_valid, rsp_o.pop_valid);
          check_field("status", want.status, rsp_o.status);
          check_field("count", want.count, rsp_o.count);
          check_field("is_empty", want.is_empty, rsp_o.is_empty);
        end
      end
      if (req_valid_i && !req_stall_o) begin
        moved = 1'b1;
        want = apply_request(req_i);
        expected_rsps = {expected_rsps, want};
        reqs_accepted++;
      end
      // Watchdog on cycles with no traffic at all
      if (moved) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no request or response moved for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Test sequence
  initial begin : sequencer
    foreach (ring_mem[i]) ring_mem[i] = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: pops on empty, extreme values at both ends, fill to full, overflow
    add_req(REQ_POP_FRONT, '1);
    add_req(REQ_POP_BACK, '1);
    add_req(REQ_PUSH_BACK, '0);
    add_req(REQ_PUSH_FRONT, '1);
    add_req(REQ_POP_BACK, '0);
    add_req(REQ_POP_FRONT, '0);
    for (int i = 0; i < QDEPTH; i++)
      add_req((i % 2) ? REQ_PUSH_BACK : REQ_PUSH_FRONT,
              (i % 3 == 0) ? ~(32'h1 << (2 * i)) : (32'h1 << (2 * i + 1)));
    add_req(REQ_PUSH_FRONT, 32'hDEAD_BEEF);
    add_req(REQ_PUSH_BACK, 32'h1234_5678);
    add_req(REQ_POP_BACK, '0);
    add_req(REQ_POP_FRONT, '0);
    wait_drained();

    // Random traffic under each idling pattern
    phase = PH_STEADY;
    queue_random(140);
    wait_drained();
    phase = PH_SENDER_SLOW;
    queue_random(140);
    wait_drained();
    phase = PH_RECEIVER_SLOW;
    queue_random(140);
    wait_drained();
    phase = PH_BOTH;
    queue_random(140);
    wait_drained();

    // Long receiver hold-off with the sender still offering
    queue_random(40);
    phase = PH_HOLD;
    wait_drained();

    repeat (8) @(posedge clk_i);
    $display("Checked %0d responses for %0d requests across five traffic patterns.",
             rsps_checked, reqs_accepted);
    $display("Pops on empty: %0d, pushes on full: %0d, highest fill level: %0d.",
             empty_pops, full_pushes, fullest);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> double_ended_queue_unit.f
design/deq_pkg.sv
design/deq_cell.sv
design/double_ended_queue_unit.sv
test/double_ended_queue_unit_test.sv
